### rtl/prq_pkg.sv
// Package for the priority bitmap run queue.
// Holds the beat structs, action and status codes, and the controller command struct.
// Depends on nothing.
`timescale 1ns / 1ps

package prq_pkg;

    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [1:0] ACT_PICK    = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ALREADY_Q  = 2'd1;
    localparam logic [1:0] ST_NOT_QUEUED = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    // Levels are searched in groups of this many bits.
    localparam int GRP_SIZE = 8;
    localparam int GRP_BITS = 3;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  thread_id;
        logic [6:0]  priority_req;
        logic [15:0] load_amount;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  picked_thread;
        logic [6:0]  queued_count;
        logic [31:0] total_load;
    } result_t;

    typedef struct packed {
        logic capture;
        logic look;
        logic level;
        logic update;
    } ctrl_cmd_t;

endpackage

### rtl/prq_ctrl.sv
// Controller state machine of the run queue.
// Sequences capture, lookup, level read and update; depends on prq_pkg.
`timescale 1ns / 1ps

module prq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output prq_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOK   = 2'd1;
    localparam logic [1:0] S_LEVEL  = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:   state_next = S_LEVEL;
            S_LEVEL:  state_next = S_UPDATE;
            S_UPDATE: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.look    = (state_reg == S_LOOK);
    assign cmd.level   = (state_reg == S_LEVEL);
    assign cmd.update  = (state_reg == S_UPDATE);

endmodule

### rtl/prq_datapath.sv
// Datapath of the run queue: list memories, level bitmap, counters and result register.
// Driven by prq_ctrl commands; depends on prq_pkg.
`timescale 1ns / 1ps

module prq_datapath #(
    parameter int NUM_LEVELS  = 100,
    parameter int MAX_THREADS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  prq_pkg::ctrl_cmd_t cmd,
    input  prq_pkg::request_t  request,
    output logic               done,
    output prq_pkg::result_t   result
);

    localparam int LVL_W = $clog2(NUM_LEVELS);
    localparam int TID_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);
    localparam int NGRP  = (NUM_LEVELS + prq_pkg::GRP_SIZE - 1) / prq_pkg::GRP_SIZE;
    localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD_W = NGRP * prq_pkg::GRP_SIZE;

    // Linked-list storage; contents are only read where valid.
    logic [TID_W-1:0] head_mem [NUM_LEVELS];
    logic [TID_W-1:0] tail_mem [NUM_LEVELS];
    logic [TID_W-1:0] next_mem [MAX_THREADS];
    logic [TID_W-1:0] prev_mem [MAX_THREADS];
    logic [LVL_W-1:0] tlvl_mem [MAX_THREADS];

    logic [NUM_LEVELS-1:0]  nonempty_reg;
    logic [MAX_THREADS-1:0] queued_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [31:0]            load_reg;

    logic [1:0]       act_reg;
    logic [TID_W-1:0] tid_reg;
    logic             idok_reg;
    logic [6:0]       prio_reg;
    logic [15:0]      amount_reg;

    logic [LVL_W-1:0] tlvl_rd_reg;
    logic [NGRP-1:0]  grp_any_reg;
    logic [prq_pkg::GRP_BITS-1:0] grp_enc_reg [NGRP];

    logic [TID_W-1:0] head_rd_reg;
    logic [TID_W-1:0] tail_rd_reg;
    logic [TID_W-1:0] next_rd_reg;
    logic [TID_W-1:0] prev_rd_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic             lvl_ne_reg;
    logic             pick_any_reg;

    logic             done_reg;
    prq_pkg::result_t result_reg;

    logic [PAD_W-1:0] bm_pad;
    logic [NGRP-1:0]  grp_any;
    logic [prq_pkg::GRP_BITS-1:0] grp_enc [NGRP];
    logic [GRP_W-1:0] pick_grp;
    logic [LVL_W-1:0] pick_lvl;
    logic [LVL_W-1:0] prio_sat;
    logic [LVL_W-1:0] lvl_sel;

    logic             enq_ok;
    logic             deq_ok;
    logic             is_head;
    logic             is_tail;
    logic             queued_now;
    logic [1:0]       status_next;
    logic [CNT_W-1:0] count_next;
    logic [31:0]      load_next;
    logic [32:0]      load_sum;

    assign bm_pad = PAD_W'(nonempty_reg);

    // Per-group priority encode of the nonempty bitmap.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_enc[g] = '0;
            grp_any[g] = 1'b0;
            for (int b = 0; b < prq_pkg::GRP_SIZE; b++)
            begin
                if (bm_pad[g * prq_pkg::GRP_SIZE + b])
                begin
                    grp_enc[g] = prq_pkg::GRP_BITS'(b);
                    grp_any[g] = 1'b1;
                end
            end
        end
    end

    // Highest nonempty group from the registered group summary.
    always_comb
    begin
        pick_grp = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (grp_any_reg[g])
            begin
                pick_grp = GRP_W'(g);
            end
        end
        pick_lvl = LVL_W'({pick_grp, grp_enc_reg[pick_grp]});
    end

    assign prio_sat = (prio_reg > 7'(NUM_LEVELS - 1)) ? LVL_W'(NUM_LEVELS - 1)
                                                       : LVL_W'(prio_reg);

    always_comb
    begin
        priority case (act_reg)
            prq_pkg::ACT_ENQUEUE: lvl_sel = prio_sat;
            prq_pkg::ACT_DEQUEUE: lvl_sel = tlvl_rd_reg;
            default:              lvl_sel = pick_lvl;
        endcase
    end

    assign queued_now = queued_reg[tid_reg];
    assign enq_ok  = (act_reg == prq_pkg::ACT_ENQUEUE) && idok_reg && !queued_now;
    assign deq_ok  = (act_reg == prq_pkg::ACT_DEQUEUE) && idok_reg && queued_now;
    assign is_head = (head_rd_reg == tid_reg);
    assign is_tail = (tail_rd_reg == tid_reg);
    assign load_sum = {1'b0, load_reg} + 33'(amount_reg);

    always_comb
    begin
        status_next = prq_pkg::ST_OK;
        count_next  = count_reg;
        load_next   = load_reg;
        priority if (act_reg == prq_pkg::ACT_ENQUEUE)
        begin
            if (!idok_reg)
            begin
                status_next = prq_pkg::ST_NOT_QUEUED;
            end
            else if (queued_now)
            begin
                status_next = prq_pkg::ST_ALREADY_Q;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                load_next  = load_sum[32] ? 32'hFFFF_FFFF : load_sum[31:0];
            end
        end
        else if (act_reg == prq_pkg::ACT_DEQUEUE)
        begin
            if (!deq_ok)
            begin
                status_next = prq_pkg::ST_NOT_QUEUED;
            end
            else
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                load_next = (load_reg >= 32'(amount_reg)) ? load_reg - 32'(amount_reg)
                                                          : 32'd0;
            end
        end
        else if (act_reg == prq_pkg::ACT_PICK)
        begin
            if (!pick_any_reg)
            begin
                status_next = prq_pkg::ST_EMPTY;
            end
        end
    end

    // Memory reads and writes, no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg    <= request.action;
            tid_reg    <= TID_W'(request.thread_id);
            idok_reg   <= (32'(request.thread_id) < MAX_THREADS);
            prio_reg   <= request.priority_req;
            amount_reg <= request.load_amount;
        end
        if (cmd.look)
        begin
            tlvl_rd_reg <= tlvl_mem[tid_reg];
            grp_any_reg <= grp_any;
            for (int g = 0; g < NGRP; g++)
            begin
                grp_enc_reg[g] <= grp_enc[g];
            end
        end
        if (cmd.level)
        begin
            head_rd_reg  <= head_mem[lvl_sel];
            tail_rd_reg  <= tail_mem[lvl_sel];
            next_rd_reg  <= next_mem[tid_reg];
            prev_rd_reg  <= prev_mem[tid_reg];
            lvl_reg      <= lvl_sel;
            lvl_ne_reg   <= nonempty_reg[lvl_sel];
            pick_any_reg <= |grp_any_reg;
        end
        if (cmd.update)
        begin
            if (enq_ok)
            begin
                if (lvl_ne_reg)
                begin
                    next_mem[tail_rd_reg] <= tid_reg;
                end
                else
                begin
                    head_mem[lvl_reg] <= tid_reg;
                end
                prev_mem[tid_reg] <= tail_rd_reg;
                tail_mem[lvl_reg] <= tid_reg;
                tlvl_mem[tid_reg] <= lvl_reg;
            end
            else if (deq_ok)
            begin
                if (is_head && !is_tail)
                begin
                    head_mem[lvl_reg] <= next_rd_reg;
                end
                else if (is_tail && !is_head)
                begin
                    tail_mem[lvl_reg] <= prev_rd_reg;
                end
                else if (!is_head && !is_tail)
                begin
                    next_mem[prev_rd_reg] <= next_rd_reg;
                    prev_mem[next_rd_reg] <= prev_rd_reg;
                end
            end
            result_reg.status        <= status_next;
            result_reg.picked_thread <= ((act_reg == prq_pkg::ACT_PICK) && pick_any_reg)
                                        ? 6'(head_rd_reg) : 6'd0;
            result_reg.queued_count  <= 7'(count_next);
            result_reg.total_load    <= load_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '0;
            queued_reg   <= '0;
            count_reg    <= '0;
            load_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
            if (cmd.update)
            begin
                count_reg <= count_next;
                load_reg  <= load_next;
                if (enq_ok)
                begin
                    nonempty_reg[lvl_reg] <= 1'b1;
                    queued_reg[tid_reg]   <= 1'b1;
                end
                else if (deq_ok)
                begin
                    queued_reg[tid_reg] <= 1'b0;
                    if (is_head && is_tail)
                    begin
                        nonempty_reg[lvl_reg] <= 1'b0;
                    end
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/priority_bitmap_run_queue.sv
// Top level of the priority bitmap run queue.
// Instantiates prq_ctrl and prq_datapath; depends on prq_pkg.
`timescale 1ns / 1ps

// Usage:
// A request beat (enqueue, dequeue or pick) is accepted at a rising edge where
// start is high and busy is low. Every request produces exactly one result beat,
// shown on result for a single cycle while done is high.
// Each request passes through a capture edge, a lookup cycle that reads the
// thread's stored level and encodes the level bitmap in groups, a level cycle
// that selects the level and reads the head, tail and link memories, and an
// update cycle that writes the lists back and registers the result.
// The result is visible after the update step, and busy is
// already low in that cycle, so a new request can be accepted while the
// previous result is shown; busy stays high from the accepting edge until
// the update step, so requests are not overlapped.
// Reset clears the level bitmap, the queued flags, the thread count and the
// load sum at once; the list memories need no clearing. The receiver cannot
// stall: a result beat must be taken in the cycle it is shown.

module priority_bitmap_run_queue #(
    parameter int NUM_LEVELS  = 100,
    parameter int MAX_THREADS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  prq_pkg::request_t request,
    output logic              done,
    output prq_pkg::result_t  result
);

    prq_pkg::ctrl_cmd_t cmd;

    // The controller only sequences; all queue state lives in the datapath.
    prq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    prq_datapath #(
        .NUM_LEVELS  (NUM_LEVELS),
        .MAX_THREADS (MAX_THREADS)
    ) u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .done    (done),
        .result  (result)
    );

endmodule

### rtl/prq_checker.sv
// Port-level checker for the run queue, bound to the top level.
// Depends on prq_pkg and priority_bitmap_run_queue.
`timescale 1ns / 1ps

module prq_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input prq_pkg::result_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted beat");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##4 done)
        else $error("result beat did not follow four cycles after accept");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat shown while still busy");

    a_empty_pick: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == prq_pkg::ST_EMPTY) |-> (result.picked_thread == 6'd0))
        else $error("empty pick reported a thread");

endmodule

bind priority_bitmap_run_queue prq_checker u_prq_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
